/* rtl/tast_pkg.sv */
`default_nettype none

package tast_pkg;

    localparam int ADDR_W  = 12;
    localparam int AGE_W   = 8;
    localparam int TEXT_W  = 56;
    localparam int INDEX_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_CEILING = 12'd2048;
    localparam logic [ADDR_W-1:0] LIMIT_RESET  = 12'd99;

    typedef struct packed {
        logic [TEXT_W-1:0] name;
        logic              thrown;
        logic [AGE_W-1:0]  age;
        logic [ADDR_W-1:0] addr;
    } t_slot;

    typedef struct packed {
        logic             name_hit;
        logic             addr_hit;
        logic             age_gt;
        logic [AGE_W-1:0] age_next;
    } t_eval;

endpackage

`default_nettype wire

/* rtl/tast_slot_store.sv */
`default_nettype none

module tast_slot_store #(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rd_en,
    input  wire [IDX_W-1:0]      i_rd_idx,
    output tast_pkg::t_slot      o_rd_slot,
    input  wire                  i_wr_en,
    input  wire [IDX_W-1:0]      i_wr_idx,
    input  tast_pkg::t_slot      i_wr_slot
);

    tast_pkg::t_slot       r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    tast_pkg::t_slot       r_rd_word;
    logic                  r_rd_valid;

    // unwritten slots read as the reset value (all zero)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_slot;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_slot = r_rd_valid ? r_rd_word : '0;

endmodule

`default_nettype wire

/* rtl/tast_slot_eval.sv */
`default_nettype none

module tast_slot_eval (
    input  tast_pkg::t_slot                     i_slot,
    input  wire [tast_pkg::ADDR_W-1:0]          i_key_addr,
    input  wire [tast_pkg::TEXT_W-1:0]          i_key_text,
    input  wire [tast_pkg::AGE_W-1:0]           i_top_age,
    output tast_pkg::t_eval                     o_eval
);

    always_comb begin
        o_eval.name_hit = (i_slot.name == i_key_text);
        o_eval.addr_hit = (i_slot.addr == i_key_addr);
        o_eval.age_gt   = (i_slot.age > i_top_age);
        o_eval.age_next = i_slot.age + tast_pkg::AGE_W'(1);
    end

endmodule

`default_nettype wire

/* rtl/turnout_age_slot_table_core.sv */
// Accessory slot table with age-based replacement.
// Input channel: i_in_valid / o_in_ready carry one command transaction
// (address, numeric name, text name and flags). Output channel:
// o_out_valid / i_out_ready carry one result transaction per command:
// status, slot index, slot address and thrown bit.
// i_cfg_we writes i_cfg_data into the display limit; write only when idle.
// Each command walks the slot memory up to three times through one read
// port and one shared compare/increment unit, one slot per cycle:
//   name lookup (only for a short text-only name)
//   age / address scan
//   write-back with aging
// plus control states between and after the passes; a rejected command
// skips the scan and write-back. One command is in flight at a time.
// The result sits in an output register; while the receiver stalls, a
// finished result waits there and the next command may already be taken.
// Reset (synchronous, active low) empties the table through per-slot valid
// bits and sets the display limit to 99.
`default_nettype none

module turnout_age_slot_table_core #(
    parameter int SLOT_COUNT = 8,
    parameter int NAME_CHARS = 7
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [tast_pkg::ADDR_W-1:0]     i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [tast_pkg::ADDR_W-1:0]     i_address_value,
    input  wire [tast_pkg::ADDR_W-1:0]     i_name_value,
    input  wire [tast_pkg::TEXT_W-1:0]     i_name_text,
    input  wire                            i_name_present,
    input  wire                            i_name_long,
    input  wire                            i_state_present,
    input  wire                            i_state_thrown,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_status,
    output logic [tast_pkg::INDEX_W-1:0]   o_slot_index,
    output logic [tast_pkg::ADDR_W-1:0]    o_slot_address,
    output logic                           o_slot_thrown
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [tast_pkg::TEXT_W-1:0] NAME_MASK = (NAME_CHARS >= 7) ? '1 :
        ((tast_pkg::TEXT_W'(1) << (8 * NAME_CHARS)) - tast_pkg::TEXT_W'(1));

    typedef enum logic [2:0] {
        S_IDLE, S_NAME, S_CHECK, S_SCAN, S_PICK, S_UPD, S_DONE
    } t_state;

    t_state                        r_state;
    logic [tast_pkg::ADDR_W-1:0]   r_limit;
    logic [tast_pkg::ADDR_W-1:0]   r_addr;
    logic [tast_pkg::TEXT_W-1:0]   r_text;
    logic                          r_has_name;
    logic                          r_has_state;
    logic                          r_thrown;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_pend;
    logic [IDX_W-1:0]              r_pidx;
    logic                          r_found;
    logic                          r_hit;
    logic                          r_replace;
    logic [IDX_W-1:0]              r_sel;
    logic [IDX_W-1:0]              r_oldest;
    logic [tast_pkg::AGE_W-1:0]    r_top;
    logic                          r_out_valid;
    logic                          r_res_status;
    logic                          r_out_status;
    logic [tast_pkg::INDEX_W-1:0]  r_out_index;
    logic [tast_pkg::ADDR_W-1:0]   r_out_addr;
    logic                          r_out_thrown;

    logic                          in_pass;
    logic                          rd_en;
    logic                          last;
    logic                          reject;
    logic [tast_pkg::ADDR_W-1:0]   first_addr;
    tast_pkg::t_slot               rd_slot;
    tast_pkg::t_slot               wr_slot;
    tast_pkg::t_eval               ev;

    tast_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_cnt[IDX_W-1:0]),
        .o_rd_slot (rd_slot),
        .i_wr_en   ((r_state == S_UPD) && r_pend),
        .i_wr_idx  (r_pidx),
        .i_wr_slot (wr_slot)
    );

    tast_slot_eval u_eval (
        .i_slot     (rd_slot),
        .i_key_addr (r_addr),
        .i_key_text (r_text),
        .i_top_age  (r_top),
        .o_eval     (ev)
    );

    assign in_pass    = (r_state == S_NAME) || (r_state == S_SCAN) || (r_state == S_UPD);
    assign rd_en      = in_pass && (r_cnt < CNT_W'(SLOT_COUNT));
    assign last       = r_pend && (r_pidx == IDX_W'(SLOT_COUNT - 1));
    assign first_addr = (i_address_value != '0) ? i_address_value :
                        (i_name_present ? i_name_value : '0);
    assign reject     = !r_has_state || (r_addr == '0) ||
                        (r_addr > tast_pkg::ADDR_CEILING) || (r_addr > r_limit);

    always_comb begin
        wr_slot = rd_slot;
        if (r_pidx == r_sel) begin
            wr_slot.addr   = r_addr;
            wr_slot.thrown = r_thrown;
            if (r_replace) begin
                wr_slot.age = '0;
            end
            if (r_has_name) begin
                wr_slot.name = r_text & NAME_MASK;
            end
        end else begin
            wr_slot.age = ev.age_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= tast_pkg::LIMIT_RESET;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (in_pass) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_cnt  <= r_cnt + CNT_W'(1);
                    r_pidx <= r_cnt[IDX_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_addr      <= first_addr;
                        r_text      <= i_name_text;
                        r_has_name  <= i_name_present;
                        r_has_state <= i_state_present;
                        r_thrown    <= i_state_thrown;
                        r_cnt       <= '0;
                        r_pend      <= 1'b0;
                        r_found     <= 1'b0;
                        if ((first_addr == '0) && i_name_present && !i_name_long) begin
                            r_state <= S_NAME;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_NAME: begin
                    if (r_pend && !r_found && ev.name_hit) begin
                        r_found <= 1'b1;
                        r_addr  <= rd_slot.addr;
                    end
                    if (last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cnt    <= '0;
                    r_pend   <= 1'b0;
                    r_top    <= '0;
                    r_oldest <= '0;
                    r_hit    <= 1'b0;
                    r_sel    <= '0;
                    if (reject) begin
                        r_res_status <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_res_status <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend && ev.age_gt) begin
                        r_top    <= rd_slot.age;
                        r_oldest <= r_pidx;
                    end
                    if (r_pend && !r_hit && ev.addr_hit) begin
                        r_hit <= 1'b1;
                        r_sel <= r_pidx;
                    end
                    if (last) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_cnt     <= '0;
                    r_pend    <= 1'b0;
                    r_replace <= !r_hit;
                    if (!r_hit) begin
                        r_sel <= r_oldest;
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_index  <= r_res_status ? '0 : tast_pkg::INDEX_W'(r_sel);
                        r_out_addr   <= r_res_status ? '0 : r_addr;
                        r_out_thrown <= r_res_status ? 1'b0 : r_thrown;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = r_out_index;
    assign o_slot_address = r_out_addr;
    assign o_slot_thrown  = r_out_thrown;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
        (o_slot_index == '0) && (o_slot_address == '0) && !o_slot_thrown)
        else $error("rejected result carries nonzero fields");

    a_update_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_slot_address != '0) && (o_slot_address <= tast_pkg::ADDR_CEILING))
        else $error("updated slot address out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOT_COUNT))
        else $error("slot counter past table size");

endmodule

`default_nettype wire

/* tb/tb_turnout_age_slot_table_core.sv */
`default_nettype none

module tb_turnout_age_slot_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W  = tast_pkg::ADDR_W;
    localparam int AGE_W   = tast_pkg::AGE_W;
    localparam int TEXT_W  = tast_pkg::TEXT_W;
    localparam int INDEX_W = tast_pkg::INDEX_W;
    localparam logic [ADDR_W-1:0] ADDR_CEILING = tast_pkg::ADDR_CEILING;
    localparam logic [ADDR_W-1:0] LIMIT_RESET  = tast_pkg::LIMIT_RESET;

    localparam int CLK_PERIOD  = 10;
    localparam int SLOT_COUNT  = 8;
    localparam int NAME_CHARS  = 7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int ADDR_POOL   = 12;
    localparam int NAME_POOL   = 10;

    localparam logic STATUS_UPDATED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [TEXT_W-1:0] NAME_KEEP =
        TEXT_W'((64'd1 << (8 * NAME_CHARS)) - 64'd1);

    typedef struct packed {
        logic [ADDR_W-1:0] address_value;
        logic [ADDR_W-1:0] name_value;
        logic [TEXT_W-1:0] name_text;
        logic              name_present;
        logic              name_long;
        logic              state_present;
        logic              state_thrown;
    } t_command;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] slot_index;
        logic [ADDR_W-1:0]  slot_address;
        logic               slot_thrown;
    } t_slot_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [ADDR_W-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [ADDR_W-1:0]  i_address_value = '0;
    logic [ADDR_W-1:0]  i_name_value = '0;
    logic [TEXT_W-1:0]  i_name_text = '0;
    logic               i_name_present = 1'b0;
    logic               i_name_long = 1'b0;
    logic               i_state_present = 1'b0;
    logic               i_state_thrown = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_status;
    logic [INDEX_W-1:0] o_slot_index;
    logic [ADDR_W-1:0]  o_slot_address;
    logic               o_slot_thrown;

    // slot table mirror
    logic [ADDR_W-1:0] slot_addr   [SLOT_COUNT];
    logic [AGE_W-1:0]  slot_age    [SLOT_COUNT];
    logic              slot_thrown [SLOT_COUNT];
    logic [TEXT_W-1:0] slot_name   [SLOT_COUNT];
    logic [ADDR_W-1:0] accept_limit;

    t_command     cmd_queue[$];
    t_slot_result pending_results[$];

    logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
    logic [TEXT_W-1:0] name_pool [NAME_POOL];
    logic [ADDR_W-1:0] stim_limit = LIMIT_RESET;
    logic [ADDR_W-1:0] hot_address = 12'd1;

    int  idle_pct = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  stall_cycles = 0;
    int  mismatch_count = 0;
    int  result_count = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;

    turnout_age_slot_table_core #(
        .SLOT_COUNT (SLOT_COUNT),
        .NAME_CHARS (NAME_CHARS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_address_value (i_address_value),
        .i_name_value    (i_name_value),
        .i_name_text     (i_name_text),
        .i_name_present  (i_name_present),
        .i_name_long     (i_name_long),
        .i_state_present (i_state_present),
        .i_state_thrown  (i_state_thrown),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_slot_address  (o_slot_address),
        .o_slot_thrown   (o_slot_thrown)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Resolve the address, pick the slot, age the table; returns the slot report.
    function automatic t_slot_result table_update(t_command c);
        t_slot_result      r;
        logic [ADDR_W-1:0] target;
        logic [AGE_W-1:0]  top;
        int               oldest;
        int               sel;
        bit               found;
        r = '0;
        r.status = STATUS_REJECTED;
        found = 1'b0;
        target = c.address_value;
        if (target == '0 && c.name_present)
            target = c.name_value;
        if (target == '0 && c.name_present && !c.name_long) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!found && slot_name[i] == c.name_text) begin
                    target = slot_addr[i];
                    found = 1'b1;
                end
            end
        end
        if (!c.state_present || target == '0 || target > ADDR_CEILING ||
            target > accept_limit)
            return r;

        top = '0;
        oldest = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_age[i] > top) begin
                top = slot_age[i];
                oldest = i;
            end
        end
        sel = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel < 0 && slot_addr[i] == target)
                sel = i;
        end
        if (sel < 0) begin
            sel = oldest;
            slot_addr[sel] = target;
            slot_age[sel] = '0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i != sel)
                slot_age[i] = slot_age[i] + 1'b1;
        end
        slot_thrown[sel] = c.state_thrown;
        if (c.name_present)
            slot_name[sel] = c.name_text & NAME_KEEP;

        r.status = STATUS_UPDATED;
        r.slot_index = sel[INDEX_W-1:0];
        r.slot_address = slot_addr[sel];
        r.slot_thrown = slot_thrown[sel];
        return r;
    endfunction

    function automatic t_command make_command(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] nval,
                                              logic [TEXT_W-1:0] text, logic np, logic nl,
                                              logic sp, logic st);
        t_command c;
        c.address_value = addr;
        c.name_value = nval;
        c.name_text = text;
        c.name_present = np;
        c.name_long = nl;
        c.state_present = sp;
        c.state_thrown = st;
        return c;
    endfunction

    function automatic logic [TEXT_W-1:0] random_name();
        logic [TEXT_W-1:0] t;
        int n;
        t = TEXT_W'({$urandom, $urandom});
        n = $urandom_range(7, 1);
        for (int b = n; b < 7; b++)
            t[8*b +: 8] = 8'h00;
        return t;
    endfunction

    function automatic t_command random_command(bit hot);
        t_command c;
        int kind;
        c = '0;
        c.state_present = ($urandom_range(99) < 94);
        c.state_thrown = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (hot && kind < 85) begin
            c.address_value = hot_address;
            c.name_value = ADDR_W'($urandom);
        end else if (kind < 45) begin
            c.address_value = addr_pool[$urandom_range(ADDR_POOL - 1)];
            c.name_value = ADDR_W'($urandom);
            c.name_present = 1'($urandom_range(1));
            c.name_long = ($urandom_range(7) == 0);
            if (c.name_present)
                c.name_text = name_pool[$urandom_range(NAME_POOL - 1)];
        end else if (kind < 60) begin
            // numeric name
            c.name_present = 1'b1;
            c.name_value = addr_pool[$urandom_range(ADDR_POOL - 1)];
            c.name_text = name_pool[$urandom_range(NAME_POOL - 1)];
            c.name_long = ($urandom_range(3) == 0);
        end else if (kind < 80) begin
            // text-only name, resolved through the table
            c.name_present = 1'b1;
            c.name_long = ($urandom_range(9) == 0);
            case ($urandom_range(9))
                0: c.name_text = random_name();
                1: c.name_text = '0;
                default: c.name_text = name_pool[$urandom_range(NAME_POOL - 1)];
            endcase
        end else if (kind < 90) begin
            case ($urandom_range(3))
                0: c.address_value = stim_limit + 1'b1;
                1: c.address_value = ADDR_CEILING + 1'b1;
                2: c.address_value = ADDR_W'($urandom_range(4095, stim_limit));
                default: begin
                    c.name_present = 1'b1;
                    c.name_value = ADDR_W'($urandom_range(4095, stim_limit + 1));
                end
            endcase
        end else begin
            c.address_value = $urandom_range(1) ? ADDR_W'($urandom) : '0;
            c.name_value = ADDR_W'($urandom);
            c.name_text = TEXT_W'({$urandom, $urandom});
            c.name_present = 1'($urandom_range(1));
            c.name_long = 1'($urandom_range(1));
            c.state_present = 1'($urandom_range(1));
        end
        return c;
    endfunction

    // sender
    always @(negedge i_clk) begin : sender
        t_command c;
        logic     next_valid;
        next_valid = i_in_valid && !in_fire;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!next_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (cmd_queue.size() > 0) begin
                if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                    send_gap = $urandom_range(16);
                end else begin
                    c = cmd_queue.pop_front();
                    i_address_value <= c.address_value;
                    i_name_value <= c.name_value;
                    i_name_text <= c.name_text;
                    i_name_present <= c.name_present;
                    i_name_long <= c.name_long;
                    i_state_present <= c.state_present;
                    i_state_thrown <= c.state_thrown;
                    next_valid = 1'b1;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // receiver
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(399) < idle_pct) begin
            recv_gap = $urandom_range(16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: checks results, updates the mirror, watchdog
    always @(posedge i_clk) begin : monitor
        t_slot_result got;
        t_slot_result want;
        t_command     c;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_addr[i] = '0;
                slot_age[i] = '0;
                slot_thrown[i] = 1'b0;
                slot_name[i] = '0;
            end
            accept_limit = LIMIT_RESET;
            stall_cycles = 0;
        end else begin
            if (i_cfg_we)
                accept_limit = i_cfg_data;
            if (out_fire) begin
                got.status = o_status;
                got.slot_index = o_slot_index;
                got.slot_address = o_slot_address;
                got.slot_thrown = o_slot_thrown;
                if (pending_results.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("result %0d unexpected: status=%0d index=%0d addr=%0d thrown=%0d",
                                 result_count, got.status, got.slot_index, got.slot_address,
                                 got.slot_thrown);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.slot_index !== want.slot_index ||
                        got.slot_address !== want.slot_address ||
                        got.slot_thrown !== want.slot_thrown) begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("result %0d mismatch: exp status=%0d index=%0d addr=%0d ",
                                     result_count, want.status, want.slot_index,
                                     want.slot_address,
                                     "thrown=%0d, got status=%0d index=%0d addr=%0d thrown=%0d",
                                     want.slot_thrown, got.status,
                                     got.slot_index, got.slot_address, got.slot_thrown);
                        mismatch_count++;
                    end
                end
                result_count++;
            end
            if (in_fire) begin
                c.address_value = i_address_value;
                c.name_value = i_name_value;
                c.name_text = i_name_text;
                c.name_present = i_name_present;
                c.name_long = i_name_long;
                c.state_present = i_state_present;
                c.state_thrown = i_state_thrown;
                pending_results.push_back(table_update(c));
            end
            if (in_fire || out_fire)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [ADDR_W-1:0] lim);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= lim;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        stim_limit = lim;
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] lim, input int count, input int pct,
                             input bit hot);
        set_limit(lim);
        for (int i = 0; i < ADDR_POOL; i++)
            addr_pool[i] = (i == 0) ? lim : ADDR_W'($urandom_range(lim, 1));
        hot_address = addr_pool[1];
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            // hold the sender until the block has gone quiet
            if (i == count / 2)
                wait_drained();
            cmd_queue.push_back(random_command(hot));
        end
    endtask

    initial begin
        for (int i = 0; i < NAME_POOL; i++)
            name_pool[i] = random_name();
        idle_pct = 20;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // display limit at its reset value
        cmd_queue.push_back(make_command(12'd10, 12'd0, 56'h4241, 1'b1, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd10, 12'd0, 56'h0, 1'b0, 1'b0, 1'b0, 1'b1));
        cmd_queue.push_back(make_command(12'd0, 12'd0, 56'h0, 1'b0, 1'b0, 1'b1, 1'b0));
        cmd_queue.push_back(make_command(12'd0, 12'd20, 56'h0, 1'b0, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd0, 12'd20, 56'h3743, 1'b1, 1'b0, 1'b1, 1'b0));
        cmd_queue.push_back(make_command(12'd0, 12'd0, 56'h4241, 1'b1, 1'b0, 1'b1, 1'b0));
        cmd_queue.push_back(make_command(12'd0, 12'd0, 56'h4241, 1'b1, 1'b1, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd0, 12'd0, 56'h5a5a5a, 1'b1, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd0, 12'd0, 56'h0, 1'b1, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd99, 12'd0, 56'h0, 1'b0, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd100, 12'd0, 56'h0, 1'b0, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'hfff, 12'hfff, '1, 1'b1, 1'b1, 1'b1, 1'b1));
        for (int a = 30; a < 38; a++)
            cmd_queue.push_back(make_command(ADDR_W'(a), 12'd0, 56'h0,
                                             1'b0, 1'b0, 1'b1, 1'(a % 2)));
        cmd_queue.push_back(make_command(12'd1, 12'd0, '1, 1'b1, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd0, 12'd0, '1, 1'b1, 1'b0, 1'b1, 1'b0));
        cmd_queue.push_back(make_command(12'd0, 12'hfff, 56'h0, 1'b1, 1'b0, 1'b1, 1'b0));

        set_limit(ADDR_CEILING);
        cmd_queue.push_back(make_command(ADDR_CEILING, 12'd0, 56'h0,
                                         1'b0, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(ADDR_CEILING + 1'b1, 12'd0, 56'h0,
                                         1'b0, 1'b0, 1'b1, 1'b1));
        cmd_queue.push_back(make_command(12'd0, ADDR_CEILING, 56'h0,
                                         1'b1, 1'b0, 1'b1, 1'b0));

        run_phase(ADDR_CEILING, 150, 30, 1'b0);
        run_phase(12'd200, 320, 10, 1'b1);
        run_phase(12'd1, 60, 40, 1'b0);
        run_phase(ADDR_W'($urandom_range(2048, 1)), 150, 50, 1'b0);
        run_phase(LIMIT_RESET, 170, 0, 1'b0);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/tast_pkg.sv
rtl/tast_slot_store.sv
rtl/tast_slot_eval.sv
rtl/turnout_age_slot_table_core.sv
tb/tb_turnout_age_slot_table_core.sv
